FILE: rtl/core/tnco_pkg.sv
// Shared types, constants and the CORDIC angle table for the tone adder NCO.
`default_nettype none

package tnco_pkg;

  // Parameter defaults
  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned PHASE_BITS_DEF   = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Configuration port and register widths
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned ANGLE_W    = 32;

  // CORDIC datapath: x/y in Q2.30 with headroom, z in turns times 2^32
  localparam int unsigned XY_W    = 34;
  localparam int unsigned Z_W     = 33;
  localparam int unsigned SINE_W  = 32;
  localparam int unsigned ITER_W  = 5;
  localparam int unsigned PROD_W  = AMP_W + 1 + SINE_W;

  // Starting x, pre-scaled by the inverse CORDIC gain
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_AMPLITUDE = 4'd0,
    REG_START_PHASE    = 4'd1,
    REG_PHASE_STEP     = 4'd2,
    REG_REPLACE_MODE   = 4'd3
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_MULTIPLY,
    ST_ROUND,
    ST_SUM
  } tnco_state_e;

  // Control to the rotator
  typedef struct packed {
    logic load;
    logic run;
  } cordic_ctrl_t;

  // Control to the scale and saturate stages
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic sat_en;
  } mix_ctrl_t;

  // atan(2^-i) in turns times 2^32
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tnco_ifs.sv
// Handshake channel interfaces: sample input, sample output and register writes.
`default_nettype none

interface tnco_in_if #(
  parameter int unsigned SAMPLE_BITS = tnco_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in_buffer;

  modport source (output valid, output sample_in, output last_in_buffer, input ready);
  modport sink   (input valid, input sample_in, input last_in_buffer, output ready);
endinterface

interface tnco_out_if #(
  parameter int unsigned SAMPLE_BITS = tnco_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface tnco_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tnco_pkg::CFG_IDX_W-1:0]      index;
  logic [tnco_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tnco_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, sine out by quadrant.
`default_nettype none

module tnco_cordic #(
  parameter int unsigned CORDIC_STEPS = tnco_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  tnco_pkg::cordic_ctrl_t                  ctrl_i,
  input  wire         [tnco_pkg::ANGLE_W-1:0]     angle_i,
  output logic                                    last_o,
  output logic signed [tnco_pkg::SINE_W-1:0]      sine_o
);

  localparam int unsigned XY_W   = tnco_pkg::XY_W;
  localparam int unsigned Z_W    = tnco_pkg::Z_W;
  localparam int unsigned ITER_W = tnco_pkg::ITER_W;

  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic        [1:0]        quad_q, quad_d;
  logic        [ITER_W-1:0] iter_q, iter_d;
  logic signed [XY_W-1:0]   dx, dy, sel;
  logic signed [Z_W-1:0]    dz;

  // Load the start vector, else one micro-rotation toward z = 0
  always_comb begin
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    dz     = $signed({1'b0, tnco_pkg::atan_turn(iter_q)});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    iter_d = iter_q;
    if (ctrl_i.load) begin
      x_d    = tnco_pkg::CORDIC_X0;
      y_d    = '0;
      z_d    = $signed({3'b000, angle_i[29:0]});
      quad_d = angle_i[31:30];
      iter_d = '0;
    end else if (ctrl_i.run) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - dz;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + dz;
      end
      iter_d = iter_q + ITER_W'(1);
    end
  end

  // Iteration count is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else begin
      iter_q <= iter_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  assign last_o = (iter_q == ITER_W'(CORDIC_STEPS - 1));

  // Quadrant fold-out
  always_comb begin
    case (quad_q)
      2'd0:    sel = y_q;
      2'd1:    sel = x_q;
      2'd2:    sel = -y_q;
      default: sel = -x_q;
    endcase
  end

  assign sine_o = sel[tnco_pkg::SINE_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/tnco_mix.sv
// Amplitude scaling, rounding, and sample add with saturation, one register stage each.
`default_nettype none

module tnco_mix #(
  parameter int unsigned SAMPLE_BITS = tnco_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                   clk_i,
  input  tnco_pkg::mix_ctrl_t                   ctrl_i,
  input  wire         [tnco_pkg::AMP_W-1:0]     amp_i,
  input  wire signed  [tnco_pkg::SINE_W-1:0]    sine_i,
  input  wire signed  [SAMPLE_BITS-1:0]         sample_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_o,
  output logic                                  clipped_o
);

  localparam int unsigned PROD_W = tnco_pkg::PROD_W;
  localparam int unsigned SHIFT  = 46 - SAMPLE_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SMAX = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);

  logic signed [PROD_W-1:0]      prod_q, tone_q, sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          clip_q;

  // Sum of rounded tone and captured sample, clamped below
  always_comb begin
    sum = tone_q + PROD_W'(sample_i);
  end

  always_ff @(posedge clk_i) begin
    // Q1.15 amplitude times Q2.30 sine
    if (ctrl_i.mul_en) begin
      prod_q <= $signed({1'b0, amp_i}) * sine_i;
    end
    // Round half up to sample LSBs
    if (ctrl_i.rnd_en) begin
      tone_q <= (prod_q + HALF) >>> SHIFT;
    end
    // Saturate into the output register
    if (ctrl_i.sat_en) begin
      if (sum > SMAX) begin
        sample_q <= SMAX[SAMPLE_BITS-1:0];
        clip_q   <= 1'b1;
      end else if (sum < SMIN) begin
        sample_q <= SMIN[SAMPLE_BITS-1:0];
        clip_q   <= 1'b1;
      end else begin
        sample_q <= sum[SAMPLE_BITS-1:0];
        clip_q   <= 1'b0;
      end
    end
  end

  assign sample_o  = sample_q;
  assign clipped_o = clip_q;

endmodule

`default_nettype wire

FILE: rtl/core/tone_adder_nco.sv
// Tone adder NCO top level: registers, phase accumulator and sequencer.
// Output valid rises after the rotate, multiply, round and sum states of an input.
// Samples are taken one at a time, only in the idle state: the single shared
// CORDIC rotator does one step per cycle and serves one sample at a time.
// A finished result waits in the output register while the next sample is taken.
// Reset clears the configuration registers, the phase accumulator and control.
`default_nettype none

module tone_adder_nco #(
  parameter int unsigned SAMPLE_BITS  = tnco_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_BITS   = tnco_pkg::PHASE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = tnco_pkg::CORDIC_STEPS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tnco_in_if.sink     in_i,
  tnco_out_if.source  out_o,
  tnco_cfg_if.sink    cfg_i
);

  localparam int unsigned ANGLE_W = tnco_pkg::ANGLE_W;

  tnco_pkg::tnco_state_e   state_q, state_d;
  tnco_pkg::cordic_ctrl_t  cordic_ctrl;
  tnco_pkg::mix_ctrl_t     mix_ctrl;

  logic [tnco_pkg::AMP_W-1:0]    amp_q;
  logic [ANGLE_W-1:0]            start_q, step_q;
  logic                          replace_q;
  logic [PHASE_BITS-1:0]         acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_valid_q, out_valid_d;

  logic                          in_fire, out_free, cordic_last;
  logic [PHASE_BITS+31:0]        step_wide, start_wide, acc_wide;
  logic [ANGLE_W-1:0]            angle;
  logic signed [tnco_pkg::SINE_W-1:0] sine;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Register writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q     <= '0;
      start_q   <= '0;
      step_q    <= '0;
      replace_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (tnco_pkg::cfg_reg_e'(cfg_i.index))
        tnco_pkg::REG_TONE_AMPLITUDE: amp_q     <= cfg_i.data[tnco_pkg::AMP_W-1:0];
        tnco_pkg::REG_START_PHASE:    start_q   <= cfg_i.data[ANGLE_W-1:0];
        tnco_pkg::REG_PHASE_STEP:     step_q    <= cfg_i.data[ANGLE_W-1:0];
        tnco_pkg::REG_REPLACE_MODE:   replace_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // 32-bit turn fractions to and from accumulator width
  assign step_wide  = {step_q, PHASE_BITS'(0)};
  assign start_wide = {start_q, PHASE_BITS'(0)};
  assign acc_wide   = {acc_q, 32'h0};
  assign angle      = acc_wide[PHASE_BITS +: ANGLE_W];

  // Phase accumulator: reload after buffer end, else step and wrap
  always_comb begin
    acc_d = acc_q;
    if (in_fire) begin
      if (in_i.last_in_buffer) begin
        acc_d = start_wide[32 +: PHASE_BITS];
      end else begin
        acc_d = acc_q + step_wide[32 +: PHASE_BITS];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tnco_pkg::ST_IDLE:     if (in_i.valid) state_d = tnco_pkg::ST_ROTATE;
      tnco_pkg::ST_ROTATE:   if (cordic_last) state_d = tnco_pkg::ST_MULTIPLY;
      tnco_pkg::ST_MULTIPLY: state_d = tnco_pkg::ST_ROUND;
      tnco_pkg::ST_ROUND:    state_d = tnco_pkg::ST_SUM;
      tnco_pkg::ST_SUM:      if (out_free) state_d = tnco_pkg::ST_IDLE;
      default:               state_d = tnco_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready       = (state_q == tnco_pkg::ST_IDLE);
    cordic_ctrl.load = in_fire;
    cordic_ctrl.run  = (state_q == tnco_pkg::ST_ROTATE);
    mix_ctrl.mul_en  = (state_q == tnco_pkg::ST_MULTIPLY);
    mix_ctrl.rnd_en  = (state_q == tnco_pkg::ST_ROUND);
    mix_ctrl.sat_en  = (state_q == tnco_pkg::ST_SUM) && out_free;
  end

  // Output valid: set on result write, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (mix_ctrl.sat_en) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnco_pkg::ST_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured sample, zero in replace mode
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= replace_q ? '0 : in_i.sample_in;
    end
  end

  tnco_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cordic_ctrl),
    .angle_i (angle),
    .last_o  (cordic_last),
    .sine_o  (sine)
  );

  tnco_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk_i     (clk_i),
    .ctrl_i    (mix_ctrl),
    .amp_i     (amp_q),
    .sine_i    (sine),
    .sample_i  (sample_q),
    .sample_o  (out_o.sample_out),
    .clipped_o (out_o.clipped)
  );

  assign out_o.valid = out_valid_q;

  // Result only written into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_ctrl.sat_en |-> (!out_valid_q || out_o.ready))
    else $error("result written over an untaken result");

  // Accepted sample starts the rotation
  a_accept_rotates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == tnco_pkg::ST_ROTATE))
    else $error("accepted sample did not start rotation");

  // Phase moves only on an input transaction
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(acc_q))
    else $error("phase accumulator moved without a transaction");

  // Output valid rises only out of the sum step
  a_valid_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == tnco_pkg::ST_SUM))
    else $error("output valid raised outside the sum step");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the tone adder NCO: sample stream, tone prediction, registers.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import tnco_pkg::*;

  localparam int unsigned SW           = SAMPLE_BITS_DEF;
  localparam int unsigned ROT_STEPS    = CORDIC_STEPS_DEF;
  localparam int unsigned NUM_REGS     = 4;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned SETTLE       = CORDIC_STEPS_DEF + 8;
  localparam int unsigned END_WAIT     = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam longint ROT_X_INIT = 64'sd652032874;
  localparam int     PROD_SHIFT = 46 - SW;
  localparam longint ROUND_HALF = 64'sd1 <<< (PROD_SHIFT - 1);
  localparam longint SUM_MAX    = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SUM_MIN    = -(64'sd1 <<< (SW - 1));

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clipped;
  } mix_result_t;

  // Tone mixer predictor plus queue of mixed samples still to come out
  class tone_mix_checker;
    logic [AMP_W-1:0]   amplitude   = '0;
    logic [ANGLE_W-1:0] start_phase = '0;
    logic [ANGLE_W-1:0] phase_step  = '0;
    logic               replace     = 1'b0;
    logic [ANGLE_W-1:0] phase_acc   = '0;
    mix_result_t        pending_mixes[$];
    int                 errors      = 0;

    task report_mismatch(string what);
      if (errors < 40) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function int pending();
      return pending_mixes.size();
    endfunction

    // atan(2^-i) as a fraction of a turn, scaled by 2^32
    function longint arc_step(int i);
      case (i)
        0:       return 64'h20000000;
        1:       return 64'h12E4051E;
        2:       return 64'h09FB385B;
        3:       return 64'h051111D4;
        4:       return 64'h028B0D43;
        5:       return 64'h0145D7E1;
        6:       return 64'h00A2F61E;
        7:       return 64'h00517C55;
        8:       return 64'h0028BE53;
        9:       return 64'h00145F2F;
        10:      return 64'h000A2F98;
        11:      return 64'h000517CC;
        12:      return 64'h00028BE6;
        13:      return 64'h000145F3;
        14:      return 64'h0000A2FA;
        15:      return 64'h0000517D;
        default: return 64'h0;
      endcase
    endfunction

    // Rotation-mode CORDIC on the in-quadrant angle, quadrant fixed up after
    function longint sine_q30(logic [ANGLE_W-1:0] angle);
      longint x, y, z, dx, dy;
      int i;
      x = ROT_X_INIT;
      y = 0;
      z = longint'(angle[29:0]);
      for (i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - arc_step(i);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + arc_step(i);
        end
      end
      case (angle[31:30])
        2'd0:    return y;
        2'd1:    return x;
        2'd2:    return -y;
        default: return -x;
      endcase
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TONE_AMPLITUDE: amplitude   = data[AMP_W-1:0];
        REG_START_PHASE:    start_phase = data;
        REG_PHASE_STEP:     phase_step  = data;
        REG_REPLACE_MODE:   replace     = data[0];
        default: ;
      endcase
    endfunction

    // Predict the mixed sample for an accepted input, then advance the phase
    function void note_sample(logic signed [SW-1:0] smp, logic last_one);
      longint      base, tone, sum;
      mix_result_t res;
      base = replace ? 64'sd0 : longint'(smp);
      tone = (longint'(amplitude) * sine_q30(phase_acc) + ROUND_HALF) >>> PROD_SHIFT;
      sum = base + tone;
      res.clipped = 1'b0;
      if (sum > SUM_MAX) begin
        sum = SUM_MAX;
        res.clipped = 1'b1;
      end
      if (sum < SUM_MIN) begin
        sum = SUM_MIN;
        res.clipped = 1'b1;
      end
      res.sample = SW'(sum);
      pending_mixes.push_back(res);
      phase_acc = last_one ? start_phase : phase_acc + phase_step;
    endfunction

    task check_output(logic signed [SW-1:0] smp, logic clip);
      mix_result_t exp_mix;
      if (pending_mixes.size() == 0) begin
        report_mismatch($sformatf("output %0d with no sample pending", smp));
        return;
      end
      exp_mix = pending_mixes.pop_front();
      if (smp !== exp_mix.sample)
        report_mismatch($sformatf("sample_out %0d, expected %0d", smp, exp_mix.sample));
      if (clip !== exp_mix.clipped)
        report_mismatch($sformatf("clipped %0b, expected %0b", clip, exp_mix.clipped));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm     = 1'b0;
  int   out_hold = 0;
  int   cycles   = 0;

  tone_mix_checker mixes = new();

  tnco_in_if  #(.SAMPLE_BITS(SW)) in_ch ();
  tnco_out_if #(.SAMPLE_BITS(SW)) out_ch ();
  tnco_cfg_if                     cfg_ch ();

  tone_adder_nco uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Random idling, switched off during the calm stretch
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 20);
  endfunction

  // Watch all three channels; every transaction goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) mixes.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) mixes.note_sample(in_ch.sample_in, in_ch.last_in_buffer);
      if (out_ch.valid && out_ch.ready) mixes.check_output(out_ch.sample_out, out_ch.clipped);
    end
  end

  // Output back-pressure: random stalls, or a counted long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else begin
        out_ch.ready <= !idle_now();
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic push_sample(input logic signed [SW-1:0] smp, input logic last_one);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_in      <= smp;
    in_ch.last_in_buffer <= last_one;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering samples and wait for every mixed sample to come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (mixes.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Registers only change once the block has gone quiet
  task automatic configure(input logic [AMP_W-1:0] amp, input logic [ANGLE_W-1:0] start,
                           input logic [ANGLE_W-1:0] step, input logic repl);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_write(REG_TONE_AMPLITUDE, {16'($urandom), amp});
    cfg_write(REG_START_PHASE, start);
    cfg_write(REG_PHASE_STEP, step);
    cfg_write(REG_REPLACE_MODE, {31'($urandom), repl});
    // unused index, must leave everything alone
    cfg_write(CFG_IDX_W'($urandom_range(15, NUM_REGS)), $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [AMP_W-1:0]   amp;
    logic [ANGLE_W-1:0] start, step;
    case ($urandom_range(0, 4))
      0:       amp = '0;
      1:       amp = 16'h8000;
      2:       amp = 16'hFFFF;
      default: amp = AMP_W'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(0, 3))
      0:       start = '0;
      1:       start = '1;
      default: start = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = 32'h8000_0000;
      2:       step = '1;
      3:       step = ANGLE_W'($urandom_range(1, 1 << 24));
      default: step = $urandom;
    endcase
    configure(amp, start, step, $urandom_range(0, 3) == 0);
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    int sent, burst, phase, i;
    sent  = 0;
    phase = 0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_in      <= '0;
    in_ch.last_in_buffer <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: zero amplitude, samples pass straight through
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-16'sd1, 1'b1);

    // Full-scale tone a quarter turn per sample: clips at both rails
    configure(16'h8000, 32'h4000_0000, 32'h4000_0000, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(S_MAX, 1'b1);
    push_sample(16'sd12345, 1'b0);
    push_sample(-16'sd12345, 1'b0);

    // Amplitude above one in pure-tone mode, step of exactly half a turn;
    // the start phase here is written mid-buffer, so it only lands at the end
    configure(16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(random_sample(), 1'b1);
    push_sample(random_sample(), 1'b0);
    push_sample(random_sample(), 1'b0);

    // Step above half a turn aliases; odd start phase written mid-buffer
    configure(16'h8000, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    push_sample(random_sample(), 1'b0);
    push_sample(random_sample(), 1'b1);

    // Random phases with buffers of random length
    while (sent < RANDOM_ITEMS) begin
      random_config();
      phase++;
      burst = $urandom_range(8, 40);
      if (phase == 3) begin
        calm  = 1'b1;
        burst = 60;
      end
      if (phase == 6) begin
        out_hold = HOLD_CYCLES;
        burst    = 12;
      end
      for (i = 0; i < burst; i++) push_sample(random_sample(), $urandom_range(0, 7) == 0);
      sent += burst;
      calm = 1'b0;
    end

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (mixes.errors == 0 && mixes.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
